/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

/* hw/rtl/fbpr_pkg.sv */
// ---------------------------------------------------------------------------
// fbpr_pkg
// Shared widths, register indexes and control types of the flow outlier block.
// ---------------------------------------------------------------------------
`default_nettype none

package fbpr_pkg;

   localparam int MAX_PIXELS_LOG2_DEF = 22;
   localparam int FRAC_BITS_DEF       = 8;

   localparam int FLOW_W      = 24;               // one flow component
   localparam int DIFF_W      = FLOW_W + 1;       // magnitude of a difference
   localparam int SQ_W        = 2 * DIFF_W - 1;   // one squared difference
   localparam int SQ_SUM_W    = SQ_W + 1;         // squared endpoint error
   localparam int ERR_THR_W   = 15;
   localparam int UNK_THR_W   = 23;
   localparam int OUT_CNT_W   = 23;
   localparam int FRAC_W      = 17;
   localparam int DIV_STEPS   = 16;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int REQ_DATA_W  = 4 * FLOW_W;
   localparam int RSP_DATA_W  = 64;
   localparam int RSP_USER_W  = 2;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_ERROR_THRESHOLD   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_UNKNOWN_THRESHOLD = 8'd1;

   localparam logic [ERR_THR_W-1:0] ERR_THR_RESET = 15'd1;
   localparam logic [UNK_THR_W-1:0] UNK_THR_RESET = 23'd8388606;

   typedef struct packed {
      logic capture;
      logic square;
      logic compare;
      logic div_init;
      logic div_step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic any_valid;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* hw/rtl/fbpr_csr.sv */
// ---------------------------------------------------------------------------
// fbpr_csr
// Configuration registers: error threshold and unknown-truth threshold.
// ---------------------------------------------------------------------------
`default_nettype none

module fbpr_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [fbpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fbpr_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic [fbpr_pkg::ERR_THR_W-1:0]        error_threshold,
   output logic [fbpr_pkg::UNK_THR_W-1:0]        unknown_threshold
);
   import fbpr_pkg::*;

   logic [ERR_THR_W-1:0] err_thr_ff, err_thr_in;
   logic [UNK_THR_W-1:0] unk_thr_ff, unk_thr_in;

   assign csr_ready = 1'b1;

   always_comb begin
      err_thr_in = err_thr_ff;
      unk_thr_in = unk_thr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ERROR_THRESHOLD:   err_thr_in = csr_data[ERR_THR_W-1:0];
            REG_UNKNOWN_THRESHOLD: unk_thr_in = csr_data[UNK_THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_thr_ff <= ERR_THR_RESET;
         unk_thr_ff <= UNK_THR_RESET;
      end else begin
         err_thr_ff <= err_thr_in;
         unk_thr_ff <= unk_thr_in;
      end
   end

   assign error_threshold   = err_thr_ff;
   assign unknown_threshold = unk_thr_ff;

endmodule

`default_nettype wire

/* hw/rtl/fbpr_ctrl.sv */
// ---------------------------------------------------------------------------
// fbpr_ctrl
// Sequencer: steps a pixel through square, compare, last-pixel divide, load.
// ---------------------------------------------------------------------------
`default_nettype none

module fbpr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire fbpr_pkg::status_type status,
   output fbpr_pkg::cmd_type         cmd
);
   import fbpr_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SQUARE   = 3'd1;
   localparam logic [2:0] ST_COMPARE  = 3'd2;
   localparam logic [2:0] ST_DIV_INIT = 3'd3;
   localparam logic [2:0] ST_DIVIDE   = 3'd4;
   localparam logic [2:0] ST_LOAD     = 3'd5;

   localparam logic [STEP_W-1:0] StepLast = STEP_W'(DIV_STEPS - 1);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_COMPARE;
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = status.last ? ST_DIV_INIT : ST_LOAD;
         end
         ST_DIV_INIT: begin
            if (status.any_valid) begin
               cmd.div_init = 1'b1;
               step_in      = '0;
               state_in     = ST_DIVIDE;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == StepLast) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/fbpr_dpath.sv */
// ---------------------------------------------------------------------------
// fbpr_dpath
// Datapath: error squares, threshold compare, counters, divider, output word.
// ---------------------------------------------------------------------------
`default_nettype none

module fbpr_dpath #(
   parameter int MAX_PIXELS_LOG2 = fbpr_pkg::MAX_PIXELS_LOG2_DEF,
   parameter int FRAC_BITS       = fbpr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [fbpr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tlast,
   input  wire logic [fbpr_pkg::ERR_THR_W-1:0]  error_threshold,
   input  wire logic [fbpr_pkg::UNK_THR_W-1:0]  unknown_threshold,
   input  wire fbpr_pkg::cmd_type               cmd,
   output fbpr_pkg::status_type                 status,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [fbpr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [fbpr_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);
   import fbpr_pkg::*;

   localparam int CntW   = MAX_PIXELS_LOG2 + 1;
   localparam int LimW   = ERR_THR_W + FRAC_BITS;
   localparam int LimSqW = 2 * LimW;
   localparam int CmpW   = (LimSqW > SQ_SUM_W) ? LimSqW : SQ_SUM_W;
   localparam logic [CntW-1:0] CntCap = {1'b1, {MAX_PIXELS_LOG2{1'b0}}};

   // Capture stage: difference magnitudes and the known-truth test.
   logic [FLOW_W-1:0] est_x, est_y, truth_x, truth_y;
   logic [DIFF_W-1:0] diff_x, diff_y, dmag_x, dmag_y;
   logic [FLOW_W-1:0] tmag_x, tmag_y;
   logic              known;

   logic [DIFF_W-1:0] dmx_ff, dmx_in, dmy_ff, dmy_in;
   logic              valid_ff, valid_in, last_ff, last_in;

   assign est_x   = req_tdata[FLOW_W-1:0];
   assign est_y   = req_tdata[2*FLOW_W-1:FLOW_W];
   assign truth_x = req_tdata[3*FLOW_W-1:2*FLOW_W];
   assign truth_y = req_tdata[4*FLOW_W-1:3*FLOW_W];

   always_comb begin
      diff_x = {est_x[FLOW_W-1], est_x} - {truth_x[FLOW_W-1], truth_x};
      diff_y = {est_y[FLOW_W-1], est_y} - {truth_y[FLOW_W-1], truth_y};
      dmag_x = diff_x[DIFF_W-1] ? (~diff_x + 1'b1) : diff_x;
      dmag_y = diff_y[DIFF_W-1] ? (~diff_y + 1'b1) : diff_y;
      tmag_x = truth_x[FLOW_W-1] ? (~truth_x + 1'b1) : truth_x;
      tmag_y = truth_y[FLOW_W-1] ? (~truth_y + 1'b1) : truth_y;
      known  = (tmag_x <= {1'b0, unknown_threshold}) ||
               (tmag_y <= {1'b0, unknown_threshold});
      dmx_in   = cmd.capture ? dmag_x : dmx_ff;
      dmy_in   = cmd.capture ? dmag_y : dmy_ff;
      valid_in = cmd.capture ? known : valid_ff;
      last_in  = cmd.capture ? req_tlast : last_ff;
   end

   // Square stage. A difference magnitude stays below 2^24, so its square
   // fits in SQ_W bits.
   logic [SQ_W-1:0]     prod_x, prod_y;
   logic [SQ_W-1:0]     sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [LimW-1:0]     lim;
   logic [LimSqW-1:0]   limsq_ff, limsq_in;

   assign prod_x = SQ_W'(dmx_ff) * SQ_W'(dmx_ff);
   assign prod_y = SQ_W'(dmy_ff) * SQ_W'(dmy_ff);
   assign lim    = LimW'(error_threshold) << FRAC_BITS;

   always_comb begin
      sqx_in   = cmd.square ? prod_x : sqx_ff;
      sqy_in   = cmd.square ? prod_y : sqy_ff;
      limsq_in = LimSqW'(lim) * LimSqW'(lim);
   end

   // Compare stage, counters and divider.
   logic [CmpW-1:0]   err2;
   logic              correct;
   logic              wrong_ff, wrong_in;
   logic [CntW-1:0]   vcnt_ff, vcnt_in, ccnt_ff, ccnt_in;
   logic [CntW-1:0]   ccnt_clamp, bad_cnt;
   logic [CntW:0]     rem_ff, rem_in, rem_shift, div_num, vcnt_ext;
   logic [FRAC_W-1:0] quo_ff, quo_in;
   logic              init_ge, step_ge;

   always_comb begin
      err2       = CmpW'(sqx_ff) + CmpW'(sqy_ff);
      correct    = valid_ff && (err2 <= CmpW'(limsq_ff));
      ccnt_clamp = (ccnt_ff > vcnt_ff) ? vcnt_ff : ccnt_ff;
      bad_cnt    = vcnt_ff - ccnt_clamp;
      vcnt_ext   = {1'b0, vcnt_ff};
      div_num    = {1'b0, bad_cnt};
      init_ge    = (div_num >= vcnt_ext);
      rem_shift  = {rem_ff[CntW-1:0], 1'b0};
      step_ge    = (rem_shift >= vcnt_ext);

      wrong_in = wrong_ff;
      vcnt_in  = vcnt_ff;
      ccnt_in  = ccnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;

      if (cmd.compare) begin
         wrong_in = valid_ff && !correct;
         if (valid_ff && (vcnt_ff != CntCap)) begin
            vcnt_in = vcnt_ff + 1'b1;
         end
         if (correct && (ccnt_ff != CntCap)) begin
            ccnt_in = ccnt_ff + 1'b1;
         end
      end
      if (cmd.div_init) begin
         rem_in = init_ge ? (div_num - vcnt_ext) : div_num;
         quo_in = {{(FRAC_W-1){1'b0}}, init_ge};
      end
      if (cmd.div_step) begin
         rem_in = step_ge ? (rem_shift - vcnt_ext) : rem_shift;
         quo_in = {quo_ff[FRAC_W-2:0], step_ge};
      end
      if (cmd.load && last_ff) begin
         vcnt_in = '0;
         ccnt_in = '0;
      end
   end

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 pv_ff, pv_in, pw_ff, pw_in, done_ff, done_in;
   logic [OUT_CNT_W-1:0] vt_ff, vt_in, ct_ff, ct_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pv_in        = pv_ff;
      pw_in        = pw_ff;
      done_in      = done_ff;
      vt_in        = vt_ff;
      ct_in        = ct_ff;
      frac_in      = frac_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         pv_in        = valid_ff;
         pw_in        = wrong_ff;
         done_in      = last_ff;
         vt_in        = last_ff ? OUT_CNT_W'(vcnt_ff) : '0;
         ct_in        = last_ff ? OUT_CNT_W'(ccnt_clamp) : '0;
         frac_in      = (last_ff && (vcnt_ff != '0)) ? quo_ff : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcnt_ff      <= '0;
         ccnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcnt_ff      <= vcnt_in;
         ccnt_ff      <= ccnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dmx_ff   <= dmx_in;
      dmy_ff   <= dmy_in;
      valid_ff <= valid_in;
      last_ff  <= last_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      limsq_ff <= limsq_in;
      wrong_ff <= wrong_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      pv_ff    <= pv_in;
      pw_ff    <= pw_in;
      done_ff  <= done_in;
      vt_ff    <= vt_in;
      ct_ff    <= ct_in;
      frac_ff  <= frac_in;
   end

   assign status.last      = last_ff;
   assign status.any_valid = (vcnt_ff != '0);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2*OUT_CNT_W - FRAC_W){1'b0}}, frac_ff, ct_ff, vt_ff};
   assign rsp_tuser  = {pw_ff, pv_ff};
   assign rsp_tlast  = done_ff;

endmodule

`default_nettype wire

/* hw/rtl/flow_bad_pixel_rate.sv */
// ---------------------------------------------------------------------------
// flow_bad_pixel_rate
// Optical flow endpoint-error outlier counter with per-frame bad fraction.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Contents of one word
//   req_     in         est_x, est_y, truth_x, truth_y (tdata), last_pixel (tlast)
//   rsp_     out        totals, bad_fraction (tdata), valid, wrong (tuser), frame_done (tlast)
//   csr_     in         register index and write data
//
// An ordinary pixel goes from acceptance to the next acceptance through
// capture, square, compare and load of the output register. The last pixel of
// a frame adds a divider start and 16 restoring divider steps, which are both
// skipped when the frame had no valid pixel. The next pixel may enter while
// a finished word waits; its load stalls until that word is taken.
// Reset is synchronous and active high and clears counters, sequencer and valid.
//
`default_nettype none

`include "assert_macros.svh"

module flow_bad_pixel_rate #(
   parameter int MAX_PIXELS_LOG2 = fbpr_pkg::MAX_PIXELS_LOG2_DEF,
   parameter int FRAC_BITS       = fbpr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Pixel input.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // est_x [23:0], est_y [47:24], truth_x [71:48], truth_y [95:72]
   input  wire logic [fbpr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                             req_tlast,
   // Per-pixel result.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // valid_total [22:0], correct_total [45:23], bad_fraction [62:46], zero [63]
   output logic [fbpr_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // pixel_valid [0], pixel_wrong [1]
   output logic [fbpr_pkg::RSP_USER_W-1:0]       rsp_tuser,
   output logic                                  rsp_tlast,
   // Register writes.
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [fbpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fbpr_pkg::CSR_DATA_W-1:0]  csr_data
);
   import fbpr_pkg::*;

   logic [ERR_THR_W-1:0] error_threshold;
   logic [UNK_THR_W-1:0] unknown_threshold;
   cmd_type              cmd;
   status_type           status;

   // The user must write thresholds only while no pixel is in flight; the block itself does not enforce it.
   fbpr_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .error_threshold   (error_threshold),
      .unknown_threshold (unknown_threshold)
   );

   // The sequencer owns the input handshake; one pixel is in flight at a time.
   fbpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath owns the counters, the divider and the output register.
   fbpr_dpath #(
      .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2),
      .FRAC_BITS       (FRAC_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .error_threshold   (error_threshold),
      .unknown_threshold (unknown_threshold),
      .cmd               (cmd),
      .status            (status),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .rsp_tlast         (rsp_tlast)
   );

   // A result is loaded only into a free output register.
   `ASSERT_IMPLY(a_load_free, clock, reset, cmd.load, status.out_free)
   // After a pixel is taken, the next one waits until this one is done.
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   // A wrong pixel is always a valid pixel.
   `ASSERT_IMPLY(a_wrong_valid, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0])
   // Frame totals appear only on the frame's last word.
   `ASSERT_IMPLY(a_totals_last, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata == '0)

endmodule

`default_nettype wire
